// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/hgd_pkg.sv =====
// ----------------------------------------------------------------------------
// Haversine distance package
// Widths, codes, command/status types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hgd_pkg;

   localparam int LAT_W        = 24;
   localparam int LON_W        = 25;
   localparam int DIST_W       = 25;
   localparam int STATUS_W     = 2;
   localparam int ITER_W       = 6;   // holds iteration indexes up to 63
   localparam int CW           = 48;  // CORDIC x/y width
   localparam int AW           = 40;  // CORDIC angle width
   localparam int TAB_W        = 34;
   localparam int UW           = 27;  // folded angle differences

   localparam int ANGLE_FRAC_BITS_DEF   = 16;
   localparam int CORDIC_ITERATIONS_DEF = 32;

   localparam logic [31:0] LAT_LIMIT_DEG = 32'd90;
   localparam logic [31:0] LON_LIMIT_DEG = 32'd180;
   localparam logic [31:0] DEG2RAD_Q36   = 32'd1199381129;
   localparam logic [31:0] CORDIC_GAIN   = 32'd2608131496;
   localparam logic [31:0] TWO_RADIUS_M  = 32'd12742000;
   localparam logic [31:0] DIST_MAX      = 32'd20015087;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LAT_BAD = 2'd1;
   localparam logic [STATUS_W-1:0] ST_LON_BAD = 2'd2;

   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_LOAD     = 4'd1;
   localparam logic [3:0] OP_PREP     = 4'd2;
   localparam logic [3:0] OP_MUL      = 4'd3;
   localparam logic [3:0] OP_ROT_INIT = 4'd4;
   localparam logic [3:0] OP_ITER     = 4'd5;
   localparam logic [3:0] OP_ROT_SAVE = 4'd6;
   localparam logic [3:0] OP_P_SAVE   = 4'd7;
   localparam logic [3:0] OP_VEC_INIT = 4'd8;
   localparam logic [3:0] OP_VEC_SAVE = 4'd9;
   localparam logic [3:0] OP_D_FIRST  = 4'd10;
   localparam logic [3:0] OP_D_ADD    = 4'd11;
   localparam logic [3:0] OP_FINISH   = 4'd12;

   // multiplier operand selects
   localparam logic [2:0] M_UD  = 3'd0;
   localparam logic [2:0] M_US  = 3'd1;
   localparam logic [2:0] M_UL  = 3'd2;
   localparam logic [2:0] M_P0  = 3'd3;
   localparam logic [2:0] M_P1  = 3'd4;
   localparam logic [2:0] M_P2  = 3'd5;
   localparam logic [2:0] M_P3  = 3'd6;
   localparam logic [2:0] M_TLO = 3'd7;
   localparam logic [2:0] M_THI = 3'd0; // shares code 0; the high theta part is selected by cmd.hi, see datapath

   typedef struct packed {
      logic [3:0]        op;
      logic [2:0]        sel;
      logic              hi;    // distance multiply: high part of theta
      logic [ITER_W-1:0] iter;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] code;
      logic                origin_valid;
   } dp_status_type;

   // round(atan(2^-i) * 2^32)
   function automatic logic [TAB_W-1:0] atan_entry(input logic [ITER_W-1:0] i);
      logic [TAB_W-1:0] r;
      case (i)
         6'd0:    r = 34'd3373259426;
         6'd1:    r = 34'd1991351318;
         6'd2:    r = 34'd1052175346;
         6'd3:    r = 34'd534100635;
         6'd4:    r = 34'd268086748;
         6'd5:    r = 34'd134174063;
         6'd6:    r = 34'd67103403;
         6'd7:    r = 34'd33553749;
         6'd8:    r = 34'd16777131;
         6'd9:    r = 34'd8388597;
         6'd10:   r = 34'd4194303;
         default: begin
            if (i <= 6'd32)
               r = 34'd1 << (6'd32 - i);
            else if (i == 6'd33)
               r = 34'd1;
            else
               r = 34'd0;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/hgd_req_if.sv =====
// ----------------------------------------------------------------------------
// Position fix channel
// Valid/ready stream carrying one latitude/longitude fix per beat.
// ----------------------------------------------------------------------------
interface hgd_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [hgd_pkg::LAT_W-1:0]  latitude;
   logic signed [hgd_pkg::LON_W-1:0]  longitude;

   modport source (output valid, output latitude, output longitude, input ready);
   modport sink   (input valid, input latitude, input longitude, output ready);
endinterface

// ===== rtl/core/hgd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Distance result channel
// Valid/ready stream carrying one distance and status per beat.
// ----------------------------------------------------------------------------
interface hgd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [hgd_pkg::DIST_W-1:0]      distance_m;
   logic [hgd_pkg::STATUS_W-1:0]    status;

   modport source (output valid, output distance_m, output status, input ready);
   modport sink   (input valid, input distance_m, input status, output ready);
endinterface

// ===== rtl/core/haversine_great_circle_distance.sv =====
// ----------------------------------------------------------------------------
// Haversine great-circle distance
// Distance in metres from a stored origin fix, computed with CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one position fix per beat (latitude, longitude in units
//   of 2^-ANGLE_FRAC_BITS degree). rsp_chan returns one beat per fix:
//   distance_m and status (0 ok, 1 latitude bad, 2 longitude bad).
//   The first good fix after reset becomes the origin and returns 0.
//   Bad fixes return 0 and leave the origin untouched.
// Timing:
//   A rejected fix or the origin fix goes from the check state straight to
//   the finish state; for a distance the single shared CORDIC unit runs
//   three rotations and three vectorings back to back, one micro-rotation
//   per cycle, plus the shared multiplier. One fix is in flight at a time;
//   req ready is high only when idle, and the controller returns to idle as
//   the result is presented, so the next fix can be taken while it is held.
// Reset and stall:
//   Reset clears the origin and drops rsp valid. A held result does not
//   block the next fix: it is computed, and only its final write waits until
//   the pending beat is taken.
// ----------------------------------------------------------------------------
module haversine_great_circle_distance #(
   parameter int ANGLE_FRAC_BITS   = hgd_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_ITERATIONS = hgd_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hgd_req_if.sink     req_chan,
   hgd_rsp_if.source   rsp_chan
);

   // command and status between sequencer and datapath
   hgd_pkg::cmd_type       cmd;
   hgd_pkg::dp_status_type dp_status;

   hgd_ctrl #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // datapath holds the result register, so the beat is stable while stalled
   hgd_datapath #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_latitude   (req_chan.latitude),
      .req_longitude  (req_chan.longitude),
      .dp_status      (dp_status),
      .rsp_distance_m (rsp_chan.distance_m),
      .rsp_status     (rsp_chan.status)
   );

endmodule

// ===== rtl/core/hgd_datapath.sv =====
// ----------------------------------------------------------------------------
// Haversine datapath
// Origin store, shared CORDIC unit, shared 32x32 multiplier, result register.
// ----------------------------------------------------------------------------
module hgd_datapath #(
   parameter int ANGLE_FRAC_BITS = hgd_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hgd_pkg::cmd_type                    cmd,
   input  logic signed [hgd_pkg::LAT_W-1:0]    req_latitude,
   input  logic signed [hgd_pkg::LON_W-1:0]    req_longitude,
   output hgd_pkg::dp_status_type              dp_status,
   output logic [hgd_pkg::DIST_W-1:0]          rsp_distance_m,
   output logic [hgd_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int CW = hgd_pkg::CW;
   localparam int AW = hgd_pkg::AW;
   localparam int UW = hgd_pkg::UW;
   localparam int SH = 5 + ANGLE_FRAC_BITS;
   localparam logic signed [31:0] LAT_LIM = 32'(hgd_pkg::LAT_LIMIT_DEG << ANGLE_FRAC_BITS);
   localparam logic signed [31:0] LON_LIM = 32'(hgd_pkg::LON_LIMIT_DEG << ANGLE_FRAC_BITS);
   localparam logic [31:0] LON_FULL = 32'(LON_LIM) << 1;

   function automatic logic [31:0] clamp_q32(input logic signed [CW-1:0] v);
      logic [31:0] r;
      if (v < 0)
         r = 32'd0;
      else if (v > $signed({{(CW-32){1'b0}}, 32'hFFFF_FFFF}))
         r = 32'hFFFF_FFFF;
      else
         r = v[31:0];
      return r;
   endfunction

   logic signed [hgd_pkg::LAT_W-1:0] lat_ff, olat_ff;
   logic signed [hgd_pkg::LON_W-1:0] lon_ff, olon_ff;
   logic                             ovalid_ff;
   logic [UW-1:0]                    ud_ff, us_ff, ul_ff;
   logic [63:0]                      prod_ff, acc_ff;
   logic signed [CW-1:0]             x_ff, y_ff;
   logic signed [AW-1:0]             z_ff, theta_ff;
   logic                             rot_ff;
   logic [31:0]                      sd_ff, cd_ff, ss_ff, cs_ff, sh_ff, ch_ff;
   logic [31:0]                      p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [CW-1:0]             m1_ff;
   logic [hgd_pkg::DIST_W-1:0]       dist_ff;
   logic [hgd_pkg::STATUS_W-1:0]     status_ff;

   logic [hgd_pkg::STATUS_W-1:0]     code;
   logic signed [UW-1:0]             dlat, slat, dlon;
   logic [UW-1:0]                    ud_in, us_in, ul_abs, ul_in;
   logic [31:0]                      mul_a, mul_b;
   logic signed [CW-1:0]             dx, dy;
   logic signed [AW-1:0]             tab;
   logic                             down;
   logic [63:0]                      rnd_ang, rnd_p;
   logic [31:0]                      dist_full;

   // range check, latitude first
   always_comb begin
      if ((32'(lat_ff) < -LAT_LIM) || (32'(lat_ff) > LAT_LIM))
         code = hgd_pkg::ST_LAT_BAD;
      else if ((32'(lon_ff) < -LON_LIM) || (32'(lon_ff) > LON_LIM))
         code = hgd_pkg::ST_LON_BAD;
      else
         code = hgd_pkg::ST_OK;
   end
   assign dp_status.code         = code;
   assign dp_status.origin_valid = ovalid_ff;

   // angle differences, longitude folded into [0,180]
   always_comb begin
      dlat   = UW'(lat_ff) - UW'(olat_ff);
      slat   = UW'(lat_ff) + UW'(olat_ff);
      dlon   = UW'(lon_ff) - UW'(olon_ff);
      ud_in  = dlat < 0 ? UW'(-dlat) : UW'(dlat);
      us_in  = slat < 0 ? UW'(-slat) : UW'(slat);
      ul_abs = dlon < 0 ? UW'(-dlon) : UW'(dlon);
      ul_in  = (32'(ul_abs) > 32'(LON_LIM)) ? UW'(LON_FULL - 32'(ul_abs)) : ul_abs;
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      if (cmd.hi) begin
         mul_a = 32'(theta_ff[AW-2:18]);
         mul_b = hgd_pkg::TWO_RADIUS_M;
      end else begin
         case (cmd.sel)
            hgd_pkg::M_UD:  begin mul_a = 32'(ud_ff); mul_b = hgd_pkg::DEG2RAD_Q36; end
            hgd_pkg::M_US:  begin mul_a = 32'(us_ff); mul_b = hgd_pkg::DEG2RAD_Q36; end
            hgd_pkg::M_UL:  begin mul_a = 32'(ul_ff); mul_b = hgd_pkg::DEG2RAD_Q36; end
            hgd_pkg::M_P0:  begin mul_a = sd_ff; mul_b = ch_ff; end
            hgd_pkg::M_P1:  begin mul_a = cs_ff; mul_b = sh_ff; end
            hgd_pkg::M_P2:  begin mul_a = cd_ff; mul_b = ch_ff; end
            hgd_pkg::M_P3:  begin mul_a = ss_ff; mul_b = sh_ff; end
            hgd_pkg::M_TLO: begin mul_a = 32'(theta_ff[17:0]); mul_b = hgd_pkg::TWO_RADIUS_M; end
            default:        begin mul_a = 32'd0; mul_b = 32'd0; end
         endcase
      end
   end

   // one CORDIC micro-rotation; rotation and vectoring share the update
   always_comb begin
      dx   = y_ff >>> cmd.iter;
      dy   = x_ff >>> cmd.iter;
      tab  = AW'(hgd_pkg::atan_entry(cmd.iter));
      down = rot_ff ? (z_ff >= 0) : (y_ff <= 0);
   end

   assign rnd_ang   = prod_ff + (64'd1 << (SH - 1));
   assign rnd_p     = prod_ff + 64'h8000_0000;
   assign dist_full = acc_ff[63:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
         olat_ff   <= '0;
         olon_ff   <= '0;
      end else begin
         if ((cmd.op == hgd_pkg::OP_FINISH) && (code == hgd_pkg::ST_OK) && !ovalid_ff) begin
            ovalid_ff <= 1'b1;
            olat_ff   <= lat_ff;
            olon_ff   <= lon_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         hgd_pkg::OP_LOAD: begin
            lat_ff <= req_latitude;
            lon_ff <= req_longitude;
         end
         hgd_pkg::OP_PREP: begin
            ud_ff <= ud_in;
            us_ff <= us_in;
            ul_ff <= ul_in;
         end
         hgd_pkg::OP_MUL: prod_ff <= mul_a * mul_b;
         hgd_pkg::OP_ROT_INIT: begin
            x_ff   <= CW'(hgd_pkg::CORDIC_GAIN);
            y_ff   <= '0;
            z_ff   <= AW'(rnd_ang >> SH);
            rot_ff <= 1'b1;
         end
         hgd_pkg::OP_ITER: begin
            if (down) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - tab;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + tab;
            end
         end
         hgd_pkg::OP_ROT_SAVE: begin
            case (cmd.sel)
               3'd0:    begin sd_ff <= clamp_q32(y_ff); cd_ff <= clamp_q32(x_ff); end
               3'd1:    begin ss_ff <= clamp_q32(y_ff); cs_ff <= clamp_q32(x_ff); end
               default: begin sh_ff <= clamp_q32(y_ff); ch_ff <= clamp_q32(x_ff); end
            endcase
         end
         hgd_pkg::OP_P_SAVE: begin
            case (cmd.sel)
               3'd0:    p0_ff <= rnd_p[63:32];
               3'd1:    p1_ff <= rnd_p[63:32];
               3'd2:    p2_ff <= rnd_p[63:32];
               default: p3_ff <= rnd_p[63:32];
            endcase
         end
         hgd_pkg::OP_VEC_INIT: begin
            rot_ff <= 1'b0;
            z_ff   <= '0;
            case (cmd.sel)
               3'd0:    begin x_ff <= CW'(p0_ff); y_ff <= CW'(p1_ff); end
               3'd1:    begin x_ff <= CW'(p2_ff); y_ff <= CW'(p3_ff); end
               default: begin y_ff <= m1_ff; end   // x holds the second magnitude
            endcase
         end
         hgd_pkg::OP_VEC_SAVE: begin
            case (cmd.sel)
               3'd0:    m1_ff <= x_ff;
               3'd2:    theta_ff <= (z_ff < 0) ? '0 : z_ff;
               default: ;
            endcase
         end
         hgd_pkg::OP_D_FIRST: acc_ff <= prod_ff + 64'h8000_0000;
         hgd_pkg::OP_D_ADD:   acc_ff <= acc_ff + (prod_ff << 18);
         hgd_pkg::OP_FINISH: begin
            status_ff <= code;
            if ((code != hgd_pkg::ST_OK) || !ovalid_ff)
               dist_ff <= '0;
            else if (dist_full > hgd_pkg::DIST_MAX)
               dist_ff <= hgd_pkg::DIST_W'(hgd_pkg::DIST_MAX);
            else
               dist_ff <= dist_full[hgd_pkg::DIST_W-1:0];
         end
         default: ;
      endcase
   end

   assign rsp_distance_m = dist_ff;
   assign rsp_status     = status_ff;

endmodule

// ===== rtl/core/hgd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Haversine controller
// Sequences the datapath through three rotations, four products, three
// vectorings and the distance scaling; owns both handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hgd_ctrl #(
   parameter int CORDIC_ITERATIONS = hgd_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  hgd_pkg::dp_status_type dp_status,
   output hgd_pkg::cmd_type       cmd
);

   localparam int IW = hgd_pkg::ITER_W;
   localparam logic [IW-1:0] LAST_IT = IW'(CORDIC_ITERATIONS - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_HMUL   = 4'd2;
   localparam logic [3:0] S_RINIT  = 4'd3;
   localparam logic [3:0] S_RITER  = 4'd4;
   localparam logic [3:0] S_RSAVE  = 4'd5;
   localparam logic [3:0] S_PMUL   = 4'd6;
   localparam logic [3:0] S_PSAVE  = 4'd7;
   localparam logic [3:0] S_VINIT  = 4'd8;
   localparam logic [3:0] S_VITER  = 4'd9;
   localparam logic [3:0] S_VSAVE  = 4'd10;
   localparam logic [3:0] S_DLO    = 4'd11;
   localparam logic [3:0] S_DFIRST = 4'd12;
   localparam logic [3:0] S_DHI    = 4'd13;
   localparam logic [3:0] S_DADD   = 4'd14;
   localparam logic [3:0] S_FIN    = 4'd15;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] it_ff, it_in;
   logic [1:0]    idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      it_in        = it_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '{op: hgd_pkg::OP_NONE, sel: 3'd0, hi: 1'b0, iter: it_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = hgd_pkg::OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            idx_in = 2'd0;
            if ((dp_status.code != hgd_pkg::ST_OK) || !dp_status.origin_valid) begin
               state_in = S_FIN;
            end else begin
               cmd.op   = hgd_pkg::OP_PREP;
               state_in = S_HMUL;
            end
         end
         S_HMUL: begin
            cmd.op   = hgd_pkg::OP_MUL;
            cmd.sel  = hgd_pkg::M_UD + 3'(idx_ff);
            state_in = S_RINIT;
         end
         S_RINIT: begin
            cmd.op   = hgd_pkg::OP_ROT_INIT;
            it_in    = '0;
            state_in = S_RITER;
         end
         S_RITER: begin
            cmd.op = hgd_pkg::OP_ITER;
            it_in  = it_ff + 1'b1;
            if (it_ff == LAST_IT)
               state_in = S_RSAVE;
         end
         S_RSAVE: begin
            cmd.op  = hgd_pkg::OP_ROT_SAVE;
            cmd.sel = 3'(idx_ff);
            if (idx_ff == 2'd2) begin
               idx_in   = 2'd0;
               state_in = S_PMUL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_HMUL;
            end
         end
         S_PMUL: begin
            cmd.op   = hgd_pkg::OP_MUL;
            cmd.sel  = hgd_pkg::M_P0 + 3'(idx_ff);
            state_in = S_PSAVE;
         end
         S_PSAVE: begin
            cmd.op  = hgd_pkg::OP_P_SAVE;
            cmd.sel = 3'(idx_ff);
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == 2'd3) begin
               idx_in   = 2'd0;
               state_in = S_VINIT;
            end else begin
               state_in = S_PMUL;
            end
         end
         S_VINIT: begin
            cmd.op   = hgd_pkg::OP_VEC_INIT;
            cmd.sel  = 3'(idx_ff);
            it_in    = '0;
            state_in = S_VITER;
         end
         S_VITER: begin
            cmd.op = hgd_pkg::OP_ITER;
            it_in  = it_ff + 1'b1;
            if (it_ff == LAST_IT)
               state_in = S_VSAVE;
         end
         S_VSAVE: begin
            cmd.op  = hgd_pkg::OP_VEC_SAVE;
            cmd.sel = 3'(idx_ff);
            if (idx_ff == 2'd2) begin
               state_in = S_DLO;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_VINIT;
            end
         end
         S_DLO: begin
            cmd.op   = hgd_pkg::OP_MUL;
            cmd.sel  = hgd_pkg::M_TLO;
            state_in = S_DFIRST;
         end
         S_DFIRST: begin
            cmd.op   = hgd_pkg::OP_D_FIRST;
            state_in = S_DHI;
         end
         S_DHI: begin
            cmd.op   = hgd_pkg::OP_MUL;
            cmd.hi   = 1'b1;
            state_in = S_DADD;
         end
         S_DADD: begin
            cmd.op   = hgd_pkg::OP_D_ADD;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.op       = hgd_pkg::OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         it_ff        <= '0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         it_ff        <= it_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_IMPLIES(a_finish_free, clock, reset, cmd.op == hgd_pkg::OP_FINISH, out_free, "result overwritten while held")
   `ASSERT_NEXT(a_accept_check, clock, reset, req_valid && req_ready, state_ff == S_CHECK && !req_ready, "accepted beat not checked")
   `ASSERT_IMPLIES(a_iter_bound, clock, reset, state_ff == S_RITER || state_ff == S_VITER, it_ff <= LAST_IT, "CORDIC count overran")
   `ASSERT_NEXT(a_fin_valid, clock, reset, cmd.op == hgd_pkg::OP_FINISH, rsp_valid, "finished beat not presented")

endmodule

// ===== tb/sv/haversine_great_circle_distance_tb.sv =====
// ----------------------------------------------------------------------------
// Haversine distance testbench
// Drives position fixes with random gaps and result stalls. Each result beat
// is checked against its typed row or an integer CORDIC predictor of the unit.
// ----------------------------------------------------------------------------
module haversine_great_circle_distance_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NUM_RANDOM     = 600;
   localparam int  WATCHDOG_LIMIT = 6000;  // idle cycles before giving up
   localparam int  DRAIN_CYCLES   = 300;   // > one full distance computation
   localparam int  NUM_ATAN       = 32;
   localparam longint LAT_LIM     = 64'sd90 << 16;
   localparam longint LON_LIM     = 64'sd180 << 16;
   localparam longint ERAD2       = 64'sd12742000;
   localparam longint DEG2RAD     = 64'sd1199381129;
   localparam longint GAIN_Q32    = 64'sd2608131496;
   localparam longint MAX_DIST    = 64'sd20015087;
   localparam longint Q32_ONES    = 64'sd4294967295;

   typedef struct {
      logic [hgd_pkg::DIST_W-1:0]   metres;
      logic [hgd_pkg::STATUS_W-1:0] status;
   } result_type;

   typedef struct {
      int                           lat;
      int                           lon;
      bit                           typed;   // expectation written out below
      logic [hgd_pkg::DIST_W-1:0]   metres;
      logic [hgd_pkg::STATUS_W-1:0] status;
   } fix_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hgd_req_if req_chan ();
   hgd_rsp_if rsp_chan ();

   haversine_great_circle_distance dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #6 clock = ~clock;

   // --------------------------------------------------------------------------
   // Predictor: fixed-point haversine distance with its own origin register
   // --------------------------------------------------------------------------
   longint     arctan_q32 [NUM_ATAN];
   longint     home_lat;
   longint     home_lon;
   bit         home_set;

   result_type expected_dists [$];
   int         mismatch_count;
   bit         relaxed;     // stretch with no idling on either side

   function automatic void queue_expected(input result_type r);
      expected_dists.insert(expected_dists.size(), r);
   endfunction

   // atan(1/n) in Q60 by its power series
   function automatic longint unsigned atan_recip_q60(input longint unsigned n);
      longint unsigned pw, acc, t, k;
      pw  = (64'd1 << 60) / n;
      acc = 0;
      k   = 0;
      while (pw != 0) begin
         t = pw / (2 * k + 1);
         if (k[0]) acc = acc - t;
         else      acc = acc + t;
         pw = pw / n / n;
         k++;
      end
      return acc;
   endfunction

   function automatic longint clamp_q32(input longint v);
      if (v < 0) return 0;
      if (v > Q32_ONES) return Q32_ONES;
      return v;
   endfunction

   function automatic void sincos_q32(input longint ang, output longint s,
                                      output longint c);
      longint x, y, dx, dy;
      x = GAIN_Q32;
      y = 0;
      for (int i = 0; i < NUM_ATAN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (ang >= 0) begin
            x -= dx; y += dy; ang -= arctan_q32[i];
         end else begin
            x += dx; y -= dy; ang += arctan_q32[i];
         end
      end
      s = clamp_q32(y);
      c = clamp_q32(x);
   endfunction

   // vectoring: gain-scaled magnitude returned, angle through ang
   function automatic longint vector_q32(input longint x, input longint y,
                                         output longint ang);
      longint dx, dy;
      ang = 0;
      for (int i = 0; i < NUM_ATAN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; ang += arctan_q32[i];
         end else begin
            x -= dx; y += dy; ang -= arctan_q32[i];
         end
      end
      return x;
   endfunction

   function automatic longint half_rad_q32(input longint u);
      return (u * DEG2RAD + (64'sd1 << 20)) >>> 21;
   endfunction

   function automatic longint mulq(input longint p, input longint q);
      longint unsigned pr;
      pr = longint'(unsigned'(p)) * longint'(unsigned'(q));
      return longint'((pr + (64'd1 << 31)) >> 32);
   endfunction

   function automatic longint absl(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint arc_metres(input longint la, input longint lo);
      longint ud, us, ul, sd, cd, ss, cs, sh, ch, m1, m2, dummy, theta;
      longint unsigned d;
      ud = absl(la - home_lat);
      us = absl(la + home_lat);
      ul = absl(lo - home_lon);
      if (ul > LON_LIM) ul = 2 * LON_LIM - ul;
      sincos_q32(half_rad_q32(ud), sd, cd);
      sincos_q32(half_rad_q32(us), ss, cs);
      sincos_q32(half_rad_q32(ul), sh, ch);
      m1 = vector_q32(mulq(sd, ch), mulq(cs, sh), dummy);
      m2 = vector_q32(mulq(cd, ch), mulq(ss, sh), dummy);
      void'(vector_q32(m2, m1, theta));
      if (theta < 0) theta = 0;
      d = (longint'(unsigned'(theta)) * ERAD2 + (64'd1 << 31)) >> 32;
      return d > MAX_DIST ? MAX_DIST : longint'(d);
   endfunction

   // result of one accepted fix; updates the origin register
   function automatic result_type predict_fix(input longint la, input longint lo);
      result_type r;
      longint     m;
      r.metres = '0;
      r.status = hgd_pkg::ST_OK;
      if (la < -LAT_LIM || la > LAT_LIM) begin
         r.status = hgd_pkg::ST_LAT_BAD;
      end else if (lo < -LON_LIM || lo > LON_LIM) begin
         r.status = hgd_pkg::ST_LON_BAD;
      end else if (!home_set) begin
         home_lat = la;
         home_lon = lo;
         home_set = 1'b1;
      end else begin
         m = arc_metres(la, lo);
         r.metres = m[hgd_pkg::DIST_W-1:0];
      end
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Driver
   // --------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (relaxed) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // valid stays high across back-to-back beats: lowered only ahead of a gap
   task automatic send_fix(input int lat, input int lon, output result_type pred);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.latitude  <= lat[hgd_pkg::LAT_W-1:0];
      req_chan.longitude <= lon[hgd_pkg::LON_W-1:0];
      do @(posedge clock); while (!req_chan.ready);
      pred = predict_fix(longint'(lat), longint'(lon));
   endtask

   // --------------------------------------------------------------------------
   // Result side: random stalls and the scoreboard
   // --------------------------------------------------------------------------
   int watchdog;
   int stall_left;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else if (relaxed) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else begin
         // mostly ready, short stalls, the odd long one
         automatic int r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_chan.ready <= 1'b1;
         end else if (r < 97) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b0;
            stall_left     <= $urandom_range(10, 60);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_dists.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t unexpected result beat: dist=%0d status=%0d",
                        $realtime, rsp_chan.distance_m, rsp_chan.status);
         end else begin
            automatic result_type e = expected_dists.pop_front();
            if (e.metres !== rsp_chan.distance_m || e.status !== rsp_chan.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t mismatch: expected dist=%0d status=%0d, got dist=%0d status=%0d",
                           $realtime, e.metres, e.status, rsp_chan.distance_m,
                           rsp_chan.status);
            end
         end
      end
   end

   // idle-cycle watchdog: any accepted beat on either side resets it
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         watchdog <= 0;
      end else begin
         watchdog <= watchdog + 1;
         if (watchdog >= WATCHDOG_LIMIT) begin
            $display("** haversine_great_circle_distance: FAILED **");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   // typed rows: rejects, the origin fix; others go through the predictor
   fix_row_type fix_table [] = '{
      '{32'sh7FFFFF,  0,          1, 0, hgd_pkg::ST_LAT_BAD},   // lat max code
      '{-32'sh800000, 0,          1, 0, hgd_pkg::ST_LAT_BAD},   // lat min code
      '{5898241,      0,          1, 0, hgd_pkg::ST_LAT_BAD},   // just past +90
      '{-5898241,     0,          1, 0, hgd_pkg::ST_LAT_BAD},   // just past -90
      '{5898241,      16777215,   1, 0, hgd_pkg::ST_LAT_BAD},   // both bad: lat wins
      '{0,            11796481,   1, 0, hgd_pkg::ST_LON_BAD},   // just past +180
      '{0,            -11796481,  1, 0, hgd_pkg::ST_LON_BAD},
      '{0,            16777215,   1, 0, hgd_pkg::ST_LON_BAD},   // lon max code
      '{0,            -16777216,  1, 0, hgd_pkg::ST_LON_BAD},   // lon min code
      '{0,            0,          1, 0, hgd_pkg::ST_OK},        // origin fix
      '{0,            0,          0, 0, hgd_pkg::ST_OK},        // same point
      '{5898240,      0,          0, 0, hgd_pkg::ST_OK},        // north pole
      '{-5898240,     0,          0, 0, hgd_pkg::ST_OK},        // south pole
      '{0,            11796480,   0, 0, hgd_pkg::ST_OK},        // antipode
      '{0,            -11796480,  0, 0, hgd_pkg::ST_OK},
      '{2949120,      5898240,    0, 0, hgd_pkg::ST_OK},
      '{-8388608,     0,          1, 0, hgd_pkg::ST_LAT_BAD},   // reject after origin
      '{0,            16777215,   1, 0, hgd_pkg::ST_LON_BAD},
      '{65,           -11796480,  0, 0, hgd_pkg::ST_OK},        // tiny latitude offset
      '{-5898240,     11796480,   0, 0, hgd_pkg::ST_OK}
   };

   initial begin
      result_type pred;
      int lat, lon;
      logic [31:0] raw;
      logic signed [hgd_pkg::LAT_W-1:0] rlat;
      logic signed [hgd_pkg::LON_W-1:0] rlon;

      for (int i = 0; i < NUM_ATAN; i++) begin
         longint unsigned q;
         if (i == 0) q = 4 * atan_recip_q60(5) - atan_recip_q60(239);
         else        q = atan_recip_q60(64'd1 << i);
         arctan_q32[i] = longint'((q + (64'd1 << 27)) >> 28);
      end
      home_lat = 0;
      home_lon = 0;
      home_set = 1'b0;
      mismatch_count = 0;
      relaxed = 1'b0;
      req_chan.valid     = 1'b0;
      req_chan.latitude  = '0;
      req_chan.longitude = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (fix_table[i]) begin
         send_fix(fix_table[i].lat, fix_table[i].lon, pred);
         if (fix_table[i].typed) begin
            pred.metres = fix_table[i].metres;
            pred.status = fix_table[i].status;
         end
         queue_expected(pred);
      end

      // random fixes: mostly in range, some raw codes over the full field
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 50 == 0) relaxed = ($urandom_range(0, 3) == 0);
         if (n == NUM_RANDOM / 2) begin
            // hold off until the unit has drained
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (expected_dists.size() != 0) @(posedge clock);
         end
         case ($urandom_range(0, 9))
            0, 1: begin
               raw  = $urandom;
               rlat = raw[hgd_pkg::LAT_W-1:0];
               raw  = $urandom;
               rlon = raw[hgd_pkg::LON_W-1:0];
               lat  = rlat;
               lon  = rlon;
            end
            2: begin
               lat = $urandom_range(0, 1) ? 5898240 : -5898240;
               lon = $urandom_range(0, 1) ? 11796480 : -11796480;
            end
            default: begin
               lat = int'($urandom_range(0, 11796480)) - 5898240;
               lon = int'($urandom_range(0, 23592960)) - 11796480;
            end
         endcase
         send_fix(lat, lon, pred);
         queue_expected(pred);
      end
      req_chan.valid <= 1'b0;

      while (expected_dists.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_dists.size() == 0)
         $display("** haversine_great_circle_distance: PASSED **");
      else
         $display("** haversine_great_circle_distance: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hgd_pkg.sv
rtl/core/hgd_req_if.sv
rtl/core/hgd_rsp_if.sv
rtl/core/hgd_datapath.sv
rtl/core/hgd_ctrl.sv
rtl/core/haversine_great_circle_distance.sv
tb/sv/haversine_great_circle_distance_tb.sv
